[design/lfbc_pkg.sv]
package lfbc_pkg;

  localparam int SIZE_W = 25;
  localparam int WORD_W = 32;
  localparam int BYTE_W = 8;

  localparam logic [SIZE_W-1:0] MAX_BLOCK_RESET = SIZE_W'(1024 * 1024);
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef enum logic [2:0] {
    KIND_PAYLOAD      = 3'd0,
    KIND_OK           = 3'd1,
    KIND_HDR_MISMATCH = 3'd2,
    KIND_OVERSIZE     = 3'd3,
    KIND_TRL_MISMATCH = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_HDR1      = 3'd0,
    PH_HDR2      = 3'd1,
    PH_PAY       = 3'd2,
    PH_TRL1      = 3'd3,
    PH_TRL2_GOOD = 3'd4,
    PH_TRL2_BAD  = 3'd5
  } phase_t;

  // One classified transaction travelling from the parser to the output stage.
  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic [SIZE_W-1:0]  size;
  } item_t;

  // Sizes of 2^25 and above saturate to the all-ones field value.
  function automatic logic [SIZE_W-1:0] clip_size(input logic [WORD_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (|s[WORD_W-1:SIZE_W]) begin
      r = '1;
    end else begin
      r = s[SIZE_W-1:0];
    end
    return r;
  endfunction

endpackage

[design/lfbc_front.sv]
module lfbc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lfbc_pkg::BYTE_W-1:0] data_byte,
  input  logic                        restart,
  input  logic [lfbc_pkg::SIZE_W-1:0] max_block_size,
  input  logic                        q_full,
  output logic                        push,
  output lfbc_pkg::item_t             push_item
);
  import lfbc_pkg::*;

  phase_t              phase, phase_next;
  logic [1:0]          byte_in_word, byte_in_word_next;
  logic [WORD_W-1:0]   header_size, header_size_next;
  logic [23:0]         word_accum, word_accum_next;
  logic [SIZE_W-1:0]   bytes_left, bytes_left_next;

  phase_t              ph;
  logic [1:0]          biw;
  logic [23:0]         acc;
  logic [WORD_W-1:0]   word;
  logic [SIZE_W-1:0]   left_dec;
  logic                accept;
  logic                word_done;
  logic                word_match;
  logic                oversize;

  assign in_stall   = q_full;
  assign accept     = in_valid && !q_full;

  // A restart puts the byte at the start of a fresh header.
  assign ph         = restart ? PH_HDR1 : phase;
  assign biw        = restart ? 2'd0 : byte_in_word;
  assign acc        = restart ? 24'd0 : word_accum;
  assign word       = {data_byte, acc};
  assign word_done  = (biw == 2'd3);
  assign word_match = (word == header_size);
  assign oversize   = (header_size > {{(WORD_W-SIZE_W){1'b0}}, max_block_size});
  assign left_dec   = bytes_left - SIZE_W'(1);

  // Next state.
  always_comb begin
    phase_next        = phase;
    byte_in_word_next = byte_in_word;
    header_size_next  = header_size;
    word_accum_next   = word_accum;
    bytes_left_next   = bytes_left;
    if (accept) begin
      phase_next        = ph;
      byte_in_word_next = biw;
      word_accum_next   = acc;
      if (ph == PH_PAY) begin
        bytes_left_next = left_dec;
        if (left_dec == '0) begin
          phase_next        = PH_TRL1;
          byte_in_word_next = 2'd0;
          word_accum_next   = '0;
        end
      end else if (!word_done) begin
        byte_in_word_next = biw + 2'd1;
        case (biw)
          2'd0:    word_accum_next[7:0]   = data_byte;
          2'd1:    word_accum_next[15:8]  = data_byte;
          default: word_accum_next[23:16] = data_byte;
        endcase
      end else begin
        byte_in_word_next = 2'd0;
        word_accum_next   = '0;
        case (ph)
          PH_HDR2: begin
            if (!word_match || oversize) begin
              phase_next = PH_HDR1;
            end else if (header_size == '0) begin
              phase_next = PH_TRL1;
            end else begin
              bytes_left_next = header_size[SIZE_W-1:0];
              phase_next      = PH_PAY;
            end
          end
          PH_TRL1: begin
            phase_next = word_match ? PH_TRL2_GOOD : PH_TRL2_BAD;
          end
          PH_TRL2_GOOD: phase_next = PH_HDR1;
          PH_TRL2_BAD:  phase_next = PH_HDR1;
          default: begin
            // First header word; unused codes behave the same way.
            header_size_next = word;
            phase_next       = PH_HDR2;
          end
        endcase
      end
    end
  end

  // Outputs toward the queue.
  always_comb begin
    push           = 1'b0;
    push_item.kind = KIND_PAYLOAD;
    push_item.data = data_byte;
    push_item.last = (bytes_left <= SIZE_W'(1));
    push_item.size = clip_size(header_size);
    if (accept) begin
      if (ph == PH_PAY) begin
        push = 1'b1;
      end else if (word_done) begin
        case (ph)
          PH_HDR2: begin
            if (!word_match) begin
              push           = 1'b1;
              push_item.kind = KIND_HDR_MISMATCH;
            end else if (oversize) begin
              push           = 1'b1;
              push_item.kind = KIND_OVERSIZE;
            end
          end
          PH_TRL2_GOOD: begin
            push           = 1'b1;
            push_item.kind = word_match ? KIND_OK : KIND_TRL_MISMATCH;
          end
          PH_TRL2_BAD: begin
            push           = 1'b1;
            push_item.kind = KIND_TRL_MISMATCH;
          end
          default: push = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR1;
      byte_in_word <= 2'd0;
      header_size  <= '0;
      word_accum   <= '0;
      bytes_left   <= '0;
    end else begin
      phase        <= phase_next;
      byte_in_word <= byte_in_word_next;
      header_size  <= header_size_next;
      word_accum   <= word_accum_next;
      bytes_left   <= bytes_left_next;
    end
  end

  a_pay_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAY) |-> (bytes_left != '0))
    else $error("payload phase with no bytes left");

  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> (in_valid && !q_full))
    else $error("push without an accepted byte");

endmodule

[design/lfbc_queue.sv]
module lfbc_queue #(
  parameter int DEPTH = lfbc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lfbc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output lfbc_pkg::item_t pop_item
);
  import lfbc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  item_t         slots [DEPTH];
  logic [AW-1:0] wr_idx, rd_idx;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = slots[rd_idx];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= (wr_idx == LAST_IDX) ? '0 : wr_idx + AW'(1);
      end
      if (pop) begin
        rd_idx <= (rd_idx == LAST_IDX) ? '0 : rd_idx + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from an empty queue");

endmodule

[design/lfbc_back.sv]
module lfbc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  lfbc_pkg::item_t             q_item,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  kind,
  output logic [lfbc_pkg::BYTE_W-1:0] payload_byte,
  output logic                        last_payload,
  output logic [lfbc_pkg::SIZE_W-1:0] frame_size
);
  import lfbc_pkg::*;

  logic is_payload;

  assign pop        = q_valid && (!out_valid || !out_stall);
  assign is_payload = (q_item.kind == KIND_PAYLOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload transactions carry data and the last flag; status carries the size.
  always_ff @(posedge clk) begin
    if (pop) begin
      kind         <= q_item.kind;
      payload_byte <= is_payload ? q_item.data : '0;
      last_payload <= is_payload ? q_item.last : 1'b0;
      frame_size   <= is_payload ? '0 : q_item.size;
    end
  end

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind != KIND_PAYLOAD)) |-> (payload_byte == '0 && !last_payload))
    else $error("status transaction with payload fields set");

endmodule

[design/length_framed_block_checker_core.sv]
// Each result is written into the queue and from there into the output register.
// Throughput: one byte per cycle; the parser takes a byte each cycle the queue has room,
// and the output stage drains one queued transaction each cycle the sink does not stall.
// Reset (rst, synchronous, active high) returns the parser to the first header byte,
// empties the queue, drops any pending output and sets max_block_size to 1048576.
module length_framed_block_checker_core #(
  parameter int QUEUE_DEPTH = lfbc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [lfbc_pkg::SIZE_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lfbc_pkg::BYTE_W-1:0] data_byte,
  input  logic                        restart,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  kind,
  output logic [lfbc_pkg::BYTE_W-1:0] payload_byte,
  output logic                        last_payload,
  output logic [lfbc_pkg::SIZE_W-1:0] frame_size
);
  import lfbc_pkg::*;

  // The size limit is held here and fed to the parser for the oversize check.
  logic [SIZE_W-1:0] max_block_size;

  // Parser to queue.
  logic  push;
  item_t push_item;
  logic  q_full;

  // Queue to output stage.
  logic  q_valid;
  item_t q_item;
  logic  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_block_size <= MAX_BLOCK_RESET;
    end else if (cfg_wr_en) begin
      max_block_size <= cfg_wr_data;
    end
  end

  // The front end assembles little-endian size words, checks the header pair and
  // the trailer pair, and counts payload bytes. Every byte that produces a result
  // becomes one queued transaction; header and trailer bytes that complete nothing
  // produce none. It stalls the input only while the queue is full.
  lfbc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .restart        (restart),
    .max_block_size (max_block_size),
    .q_full         (q_full),
    .push           (push),
    .push_item      (push_item)
  );

  // A short queue lets the parser keep consuming bytes while the sink stalls.
  lfbc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_item  (q_item)
  );

  // The back end formats each transaction into the output register, zeroing the
  // fields that do not apply to its kind.
  lfbc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .last_payload (last_payload),
    .frame_size   (frame_size)
  );

endmodule
